@@ rtl/sptc_pkg.sv @@
// ----------------------------------------------------------------------------
// sptc_pkg
// Shared types, constants and the CORDIC arctangent table for the scan
// polar-to-Cartesian transform.
// ----------------------------------------------------------------------------
package sptc_pkg;

	localparam int TableLen = 24;
	localparam int CordicIterDefault = 16;
	localparam logic [15:0] GainQ16 = 16'd39797;

	// CORDIC datapath width: r*gain < 2^32, growth below 2x, sign bit
	localparam int CW = 35;
	// Angle accumulator width (signed turn units 2^-32)
	localparam int ZW = 34;

	// APB register indexes
	localparam logic [2:0] RegRangeLow  = 3'd0;
	localparam logic [2:0] RegRangeHigh = 3'd1;
	localparam logic [2:0] RegAngStart  = 3'd2;
	localparam logic [2:0] RegAngStep   = 3'd3;
	localparam logic [2:0] RegXCoefs    = 3'd4;
	localparam logic [2:0] RegYCoefs    = 3'd5;
	localparam logic [2:0] RegZCoefs    = 3'd6;

	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0: v = 32'd536870912;
			5'd1: v = 32'd316933406;
			5'd2: v = 32'd167458907;
			5'd3: v = 32'd85004756;
			5'd4: v = 32'd42667331;
			5'd5: v = 32'd21354465;
			5'd6: v = 32'd10679838;
			5'd7: v = 32'd5340245;
			5'd8: v = 32'd2670163;
			5'd9: v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// Configuration registers as seen by the datapath
	typedef struct packed {
		logic [15:0] range_low;
		logic [15:0] range_high;
		logic [31:0] angle_start;
		logic [31:0] angle_step;
		logic [59:0] x_coefs;
		logic [59:0] y_coefs;
		logic [59:0] z_coefs;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROT   = 5'b00010,
		ST_MUL   = 5'b00100,
		ST_RND   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

endpackage

@@ rtl/sptc_cordic.sv @@
// ----------------------------------------------------------------------------
// sptc_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module sptc_cordic #(
	parameter int CORDIC_ITERATIONS = sptc_pkg::CordicIterDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [15:0]                   range_mm,
	input  logic [31:0]                   angle,
	output logic                          done,
	output logic signed [sptc_pkg::CW-1:0] x_out,
	output logic signed [sptc_pkg::CW-1:0] y_out
);
	localparam int NIter = (CORDIC_ITERATIONS > sptc_pkg::TableLen) ?
		sptc_pkg::TableLen : CORDIC_ITERATIONS;
	localparam logic [4:0] LastIter = 5'(NIter - 1);

	logic signed [sptc_pkg::CW-1:0] x_q, y_q;
	logic signed [sptc_pkg::ZW-1:0] z_q;
	logic [4:0] i_q;
	logic busy_q, flip_q;

	logic [1:0] quad;
	logic [31:0] a_fold;
	logic [31:0] gain_prod;
	logic signed [sptc_pkg::CW-1:0] dx, dy;
	logic signed [sptc_pkg::ZW-1:0] at;

	assign quad = angle[31:30];
	assign a_fold = (quad == 2'b01 || quad == 2'b10) ? angle + 32'h8000_0000 : angle;
	assign gain_prod = range_mm * sptc_pkg::GainQ16;
	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = sptc_pkg::ZW'(sptc_pkg::atan_turn(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			i_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == LastIter) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					i_q <= i_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= sptc_pkg::CW'(gain_prod);
			y_q    <= '0;
			z_q    <= sptc_pkg::ZW'(signed'(a_fold));
			flip_q <= (quad == 2'b01 || quad == 2'b10);
		end else if (busy_q) begin
			if (!z_q[sptc_pkg::ZW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign x_out = flip_q ? -x_q : x_q;
	assign y_out = flip_q ? -y_q : y_q;

endmodule

@@ rtl/sptc_affine.sv @@
// ----------------------------------------------------------------------------
// sptc_affine
// Shared multiply-accumulate: six products, one at a time, then round and
// saturate each axis.
// ----------------------------------------------------------------------------
module sptc_affine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [sptc_pkg::CW-1:0] cx,
	input  logic signed [sptc_pkg::CW-1:0] sy,
	input  logic [59:0]                   x_coefs,
	input  logic [59:0]                   y_coefs,
	input  logic [59:0]                   z_coefs,
	output logic                          done,
	output logic [23:0]                   x_mm,
	output logic [23:0]                   y_mm,
	output logic [23:0]                   z_mm
);
	localparam int AW = 56;

	logic [2:0] step_q;
	logic busy_q, prod_v_q;
	logic [2:0] pstep_q;
	logic signed [52:0] prod_q;
	logic signed [AW-1:0] acc_q;
	logic [59:0] row;
	logic signed [17:0] coef;
	logic signed [sptc_pkg::CW-1:0] opnd;
	logic signed [AW-1:0] acc_next, rnd;
	logic signed [AW-32:0] shifted;
	logic [23:0] sat;

	always_comb begin
		unique case (step_q[2:1])
			2'd0: row = x_coefs;
			2'd1: row = y_coefs;
			default: row = z_coefs;
		endcase
		coef = step_q[0] ? signed'(row[41:24]) : signed'(row[59:42]);
		opnd = step_q[0] ? sy : cx;
	end

	// Second product of an axis closes it: add offset, round, saturate.
	always_comb begin
		logic [59:0] prow;
		unique case (pstep_q[2:1])
			2'd0: prow = x_coefs;
			2'd1: prow = y_coefs;
			default: prow = z_coefs;
		endcase
		acc_next = acc_q + AW'(prod_q);
		rnd = acc_next + (AW'(signed'(prow[23:0])) <<< 31) + (AW'(1) <<< 30);
		shifted = rnd[AW-1:31];
		if (shifted > 25'sd8388607) sat = 24'h7FFFFF;
		else if (shifted < -25'sd8388608) sat = 24'h800000;
		else sat = shifted[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			prod_v_q <= 1'b0;
			done     <= 1'b0;
			step_q   <= '0;
			pstep_q  <= '0;
		end else begin
			done     <= 1'b0;
			prod_v_q <= busy_q;
			pstep_q  <= step_q;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 3'd5) busy_q <= 1'b0;
				else step_q <= step_q + 3'd1;
			end
			if (prod_v_q && pstep_q == 3'd5) done <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= coef * opnd;
		if (prod_v_q) begin
			if (!pstep_q[0]) acc_q <= AW'(prod_q);
			else begin
				acc_q <= '0;
				unique case (pstep_q[2:1])
					2'd0: x_mm <= sat;
					2'd1: y_mm <= sat;
					default: z_mm <= sat;
				endcase
			end
		end
	end

endmodule

@@ rtl/scan_polar_to_cartesian_transform.sv @@
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian_transform
// Lidar range sample to transformed Cartesian point, iterative CORDIC plus
// one shared multiplier for the affine rows.
// ----------------------------------------------------------------------------
// Sequence: an in-window sample passes through the CORDIC loop, a handoff
//   to the affine block, six passes through the shared multiplier, the close
//   of the last row and the raising of m_tvalid; an out-of-window sample
//   presents its result the cycle after acceptance.
// Throughput: one sample at a time; s_tready is low from acceptance until
//   the result is taken.
// Reset: arst_n clears control, beam angle, scan count and the configuration
//   registers to their documented reset values.
module scan_polar_to_cartesian_transform #(
	parameter int CORDIC_ITERATIONS = sptc_pkg::CordicIterDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// Sample stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // range_mm[15:0], intensity_in[31:16], has_intensity[32]
	input  logic        s_tuser,  // first_of_scan
	input  logic        s_tlast,  // last_of_scan
	// Point stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [111:0] m_tdata, // point_valid[0], x_mm[24:1], y_mm[48:25], z_mm[72:49],
	                              // intensity_out[88:73], intensity_valid[89],
	                              // scan_number[105:90]
	output logic        m_tlast,  // end_of_scan
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	sptc_pkg::cfg_t cfg_q;
	sptc_pkg::state_t state_q;

	logic [31:0] beam_angle_q;
	logic [15:0] scan_count_q;

	// Captured request
	logic [15:0] inten_q, scan_num_q;
	logic        valid_q, has_int_q, last_q;

	logic        cor_start, cor_done, aff_start, aff_done;
	logic signed [sptc_pkg::CW-1:0] cx, sy;
	logic [23:0] x_mm, y_mm, z_mm;

	logic        s_fire, m_fire, wr;
	logic [2:0]  reg_idx;
	logic [15:0] s_range;
	logic [31:0] ang;
	logic        in_win;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign reg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low   <= 16'd0;
			cfg_q.range_high  <= 16'hFFFF;
			cfg_q.angle_start <= '0;
			cfg_q.angle_step  <= '0;
			cfg_q.x_coefs     <= 60'd1 << 57;
			cfg_q.y_coefs     <= 60'd1 << 39;
			cfg_q.z_coefs     <= '0;
		end else if (wr) begin
			unique case (reg_idx)
				sptc_pkg::RegRangeLow:  cfg_q.range_low   <= pwdata[15:0];
				sptc_pkg::RegRangeHigh: cfg_q.range_high  <= pwdata[15:0];
				sptc_pkg::RegAngStart:  cfg_q.angle_start <= pwdata[31:0];
				sptc_pkg::RegAngStep:   cfg_q.angle_step  <= pwdata[31:0];
				sptc_pkg::RegXCoefs:    cfg_q.x_coefs     <= pwdata[59:0];
				sptc_pkg::RegYCoefs:    cfg_q.y_coefs     <= pwdata[59:0];
				sptc_pkg::RegZCoefs:    cfg_q.z_coefs     <= pwdata[59:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			sptc_pkg::RegRangeLow:  prdata = {48'd0, cfg_q.range_low};
			sptc_pkg::RegRangeHigh: prdata = {48'd0, cfg_q.range_high};
			sptc_pkg::RegAngStart:  prdata = {32'd0, cfg_q.angle_start};
			sptc_pkg::RegAngStep:   prdata = {32'd0, cfg_q.angle_step};
			sptc_pkg::RegXCoefs:    prdata = {4'd0, cfg_q.x_coefs};
			sptc_pkg::RegYCoefs:    prdata = {4'd0, cfg_q.y_coefs};
			sptc_pkg::RegZCoefs:    prdata = {4'd0, cfg_q.z_coefs};
			default:                prdata = '0;
		endcase
	end

	// Request acceptance and beam angle bookkeeping
	assign s_tready = (state_q == sptc_pkg::ST_IDLE);
	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;
	assign s_range = s_tdata[15:0];
	assign ang = s_tuser ? cfg_q.angle_start : beam_angle_q;
	assign in_win = (s_range > cfg_q.range_low) && (s_range < cfg_q.range_high);
	assign cor_start = s_fire && in_win;
	assign aff_start = cor_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sptc_pkg::ST_IDLE;
			beam_angle_q <= '0;
			scan_count_q <= '0;
		end else begin
			unique case (state_q)
				sptc_pkg::ST_IDLE: begin
					if (s_fire) begin
						beam_angle_q <= ang + cfg_q.angle_step;
						if (s_tlast) scan_count_q <= scan_count_q + 16'd1;
						state_q <= in_win ? sptc_pkg::ST_ROT : sptc_pkg::ST_OUT;
					end
				end
				sptc_pkg::ST_ROT: if (cor_done) state_q <= sptc_pkg::ST_MUL;
				sptc_pkg::ST_MUL: if (aff_done) state_q <= sptc_pkg::ST_OUT;
				sptc_pkg::ST_RND: state_q <= sptc_pkg::ST_OUT;
				sptc_pkg::ST_OUT: if (m_fire) state_q <= sptc_pkg::ST_IDLE;
				default: state_q <= sptc_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			inten_q    <= s_tdata[31:16];
			has_int_q  <= s_tdata[32];
			last_q     <= s_tlast;
			scan_num_q <= scan_count_q;
			valid_q    <= in_win;
		end
	end

	sptc_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cor_start),
		.range_mm (s_range),
		.angle    (ang),
		.done     (cor_done),
		.x_out    (cx),
		.y_out    (sy)
	);

	sptc_affine u_affine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (aff_start),
		.cx      (cx),
		.sy      (sy),
		.x_coefs (cfg_q.x_coefs),
		.y_coefs (cfg_q.y_coefs),
		.z_coefs (cfg_q.z_coefs),
		.done    (aff_done),
		.x_mm    (x_mm),
		.y_mm    (y_mm),
		.z_mm    (z_mm)
	);

	// Result; invalid samples report zeros for coordinates and intensity.
	assign m_tvalid = (state_q == sptc_pkg::ST_OUT);
	assign m_tlast  = last_q;
	assign m_tdata  = {6'd0, scan_num_q, valid_q && has_int_q,
		(valid_q && has_int_q) ? inten_q : 16'd0,
		valid_q ? z_mm : 24'd0, valid_q ? y_mm : 24'd0, valid_q ? x_mm : 24'd0,
		valid_q};

endmodule
